FILE: rtl/wifi_eapol_frame_classifier_assert.svh
// assertion macros for the eapol frame classifier
`ifndef WIFI_EAPOL_FRAME_CLASSIFIER_ASSERT_SVH
`define WIFI_EAPOL_FRAME_CLASSIFIER_ASSERT_SVH

// same-cycle implication, clocked on clk with reset disable
`define WEFC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wefc assertion failed");

// next-cycle implication
`define WEFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wefc assertion failed");

`endif

FILE: rtl/wefc_pkg.sv
// package: constants, result type and helpers for the eapol frame classifier
package wefc_pkg;

    localparam int EAPOL_CAPACITY_DEFAULT = 256;
    localparam int ESSID_LIMIT_DEFAULT    = 32;
    localparam int FRAME_LIMIT_DEFAULT    = 65535;

    localparam logic [15:0] FT_MASK    = 16'h000c;
    localparam logic [15:0] ST_MASK    = 16'h00f0;
    localparam logic [15:0] FT_DATA    = 16'h0008;
    localparam logic [15:0] ST_BEACON  = 16'h0080;
    localparam logic [15:0] ST_PRESP   = 16'h0050;
    localparam logic [15:0] ST_PREQ    = 16'h0040;
    localparam logic [15:0] ST_QOS     = 16'h0080;
    localparam logic [15:0] DS_TO      = 16'h0100;
    localparam logic [15:0] DS_FROM    = 16'h0200;
    localparam logic [7:0]  LLC_SAP    = 8'haa;
    localparam logic [7:0]  LLC_CTRL   = 8'h03;
    localparam logic [15:0] DOT1X_TYPE = 16'h8e88;
    localparam logic [15:0] AUTH_LEN   = 16'd99;

    typedef enum logic [1:0] {
        PH_SCAN = 2'd0,
        PH_CAND = 2'd1,
        PH_DONE = 2'd2,
        PH_STOP = 2'd3
    } scan_phase_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_RADIO = 2'd1,
        ERR_OVER  = 2'd2
    } frame_error_t;

    localparam logic [1:0] TAG_SSID  = 2'd0;
    localparam logic [1:0] TAG_NONCE = 2'd1;
    localparam logic [1:0] TAG_EAPOL = 2'd2;
    localparam logic [1:0] TAG_MIC   = 2'd3;

    localparam logic [1:0] VERD_DROP    = 2'd0;
    localparam logic [1:0] VERD_NETWORK = 2'd1;
    localparam logic [1:0] VERD_HSHAKE  = 2'd2;
    localparam logic [1:0] VERD_RADIO   = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [1:0]  tag;
        logic [7:0]  value;
        logic [7:0]  index;
        logic [1:0]  verdict;
        logic [1:0]  msg;
        logic [2:0]  kver;
        logic [63:0] rc;
        logic [47:0] ap;
        logic [47:0] sta;
        logic [8:0]  len;
        logic        last;
    } result_t;

    function automatic result_t byte_result(logic [1:0] tag, logic [7:0] value,
                                            logic [7:0] index);
        result_t r;
        r       = '0;
        r.tag   = tag;
        r.value = value;
        r.index = index;
        return r;
    endfunction

    function automatic logic [1:0] msg_of(logic [15:0] ki);
        logic [1:0] m;
        if (ki[7])
            m = ki[6] ? 2'd3 : 2'd1;
        else
            m = ki[9] ? 2'd0 : 2'd2;
        return m;
    endfunction

endpackage

FILE: rtl/wifi_eapol_frame_classifier.sv
// top level: 802.11 frame classifier for network records and eapol-key messages
// Takes one frame byte per cycle (in_valid/in_ready); each byte updates the per-frame
// header, tag-scan and key registers in one pass and queues zero to two requests in a
// four-entry result queue, so a byte is accepted every cycle while the queue has room
// for two. Output drains one request per cycle while out_ready is high, so bytes that
// give two requests (nonce plus eapol, eapol plus mic, or a byte plus the verdict on
// frame end) fill the queue faster than it drains. Tagged bytes are sent speculatively;
// the verdict at frame end says whether they belong to a record or handshake.
// radiotap_mode is sampled on the first byte of each frame.
`include "wifi_eapol_frame_classifier_assert.svh"

module wifi_eapol_frame_classifier #(
    parameter int EAPOL_CAPACITY = wefc_pkg::EAPOL_CAPACITY_DEFAULT,
    parameter int ESSID_LIMIT    = wefc_pkg::ESSID_LIMIT_DEFAULT,
    parameter int FRAME_LIMIT    = wefc_pkg::FRAME_LIMIT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [1:0]  byte_tag,
    output logic [7:0]  byte_value,
    output logic [7:0]  byte_index,
    output logic [1:0]  verdict,
    output logic [1:0]  message_number,
    output logic [2:0]  key_version,
    output logic [63:0] replay_count,
    output logic [47:0] ap_mac,
    output logic [47:0] sta_mac,
    output logic [8:0]  captured_length,
    output logic        run_last
);

    logic                   radiotap_mode_reg;
    logic                   frame_mode_reg, frame_mode_next;
    logic [15:0]            pos_reg, pos_next;
    logic [15:0]            prefix_reg, prefix_next;
    logic [15:0]            fcw_reg, fcw_next;
    logic [47:0]            a1_reg, a1_next, a2_reg, a2_next, a3_reg, a3_next;
    logic [15:0]            cursor_reg, cursor_next;
    logic [15:0]            ttl_reg, ttl_next;
    logic                   ssid_found_reg, ssid_found_next;
    logic                   llc_reg, llc_next;
    logic [15:0]            ki_reg, ki_next;
    logic [15:0]            body_reg, body_next;
    logic [15:0]            kdl_reg, kdl_next;
    logic [63:0]            replay_reg, replay_next;
    wefc_pkg::frame_error_t ferr_reg, ferr_next;
    wefc_pkg::scan_phase_t  scan_reg, scan_next;

    wefc_pkg::result_t      res0, res1;
    logic [1:0]             nres;

    wefc_pkg::result_t      queue_reg [4];
    logic [1:0]             wr_ptr_reg, rd_ptr_reg;
    logic [2:0]             count_reg;
    logic                   in_acc, out_acc;

    assign in_ready  = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;

    always_comb
    begin
        logic                  fm;
        logic                  part;
        logic [15:0]           p;
        logic [16:0]           start, nxt, el;
        logic [15:0]           lo;
        logic [15:0]           i;
        logic [2:0]            k;
        logic [1:0]            m;
        logic                  dok, bad;
        logic [3:0]            c_en;
        wefc_pkg::result_t     c_res [4];
        wefc_pkg::result_t     vr;
        logic [15:0]           len;
        logic [1:0]            cnt;

        pos_next        = pos_reg;
        prefix_next     = prefix_reg;
        fcw_next        = fcw_reg;
        a1_next         = a1_reg;
        a2_next         = a2_reg;
        a3_next         = a3_reg;
        cursor_next     = cursor_reg;
        ttl_next        = ttl_reg;
        ssid_found_next = ssid_found_reg;
        llc_next        = llc_reg;
        ki_next         = ki_reg;
        body_next       = body_reg;
        kdl_next        = kdl_reg;
        replay_next     = replay_reg;
        ferr_next       = ferr_reg;
        scan_next       = scan_reg;
        fm              = (pos_reg == 16'd0) ? radiotap_mode_reg : frame_mode_reg;
        frame_mode_next = fm;
        part            = 1'b0;
        p               = pos_reg;
        start           = '0;
        nxt             = '0;
        el              = '0;
        lo              = 16'd24;
        i               = '0;
        k               = '0;
        m               = '0;
        dok             = 1'b0;
        bad             = 1'b0;
        c_en            = '0;
        for (int j = 0; j < 4; j++)
            c_res[j] = '0;
        vr              = '0;
        len             = '0;
        cnt             = '0;
        res0            = '0;
        res1            = '0;

        if ({1'b0, pos_reg} + 17'd1 >= 17'(FRAME_LIMIT))
            ferr_next = wefc_pkg::ERR_OVER;
        else if (ferr_reg == wefc_pkg::ERR_NONE)
        begin
            part = 1'b1;
            if (fm)
            begin
                if (pos_reg == 16'd0 && frame_byte != 8'd0)
                    ferr_next = wefc_pkg::ERR_RADIO;
                else if (pos_reg == 16'd2)
                    prefix_next = {8'd0, frame_byte};
                else if (pos_reg == 16'd3)
                begin
                    prefix_next = {frame_byte, prefix_reg[7:0]};
                    if (prefix_next < 16'd8)
                        ferr_next = wefc_pkg::ERR_RADIO;
                end
                if (ferr_next != wefc_pkg::ERR_NONE || pos_reg < 16'd8 ||
                    pos_reg < prefix_next)
                    part = 1'b0;
                else
                    p = pos_reg - prefix_next;
            end
        end

        if (part)
        begin
            if (p == 16'd0)
                fcw_next = {8'd0, frame_byte};
            else if (p == 16'd1)
            begin
                fcw_next  = {frame_byte, fcw_reg[7:0]};
                scan_next = wefc_pkg::PH_STOP;
                if ((fcw_next & wefc_pkg::FT_MASK) == 16'd0)
                begin
                    if ((fcw_next & wefc_pkg::ST_MASK) == wefc_pkg::ST_BEACON ||
                        (fcw_next & wefc_pkg::ST_MASK) == wefc_pkg::ST_PRESP)
                    begin
                        cursor_next = 16'd36;
                        scan_next   = wefc_pkg::PH_SCAN;
                    end
                    else if ((fcw_next & wefc_pkg::ST_MASK) == wefc_pkg::ST_PREQ)
                    begin
                        cursor_next = 16'd24;
                        scan_next   = wefc_pkg::PH_SCAN;
                    end
                end
            end
            else if (p >= 16'd4 && p < 16'd10)
                a1_next = {a1_reg[39:0], frame_byte};
            else if (p >= 16'd10 && p < 16'd16)
                a2_next = {a2_reg[39:0], frame_byte};
            else if (p >= 16'd16 && p < 16'd22)
            begin
                a3_next = {a3_reg[39:0], frame_byte};
                if (p == 16'd21 && a3_next == {48{1'b1}})
                    scan_next = wefc_pkg::PH_STOP;
            end

            if (p >= 16'd22)
            begin
                unique case (scan_reg)
                    wefc_pkg::PH_SCAN:
                    begin
                        if (p == cursor_reg)
                            ttl_next = {frame_byte, 8'd0};
                        else if ({1'b0, p} == {1'b0, cursor_reg} + 17'd1)
                        begin
                            ttl_next = {ttl_reg[15:8], frame_byte};
                            if (ttl_reg[15:8] == 8'd0 &&
                                {1'b0, frame_byte} < 9'(ESSID_LIMIT))
                                scan_next = wefc_pkg::PH_CAND;
                            else
                            begin
                                nxt = {1'b0, cursor_reg} + 17'd2 + {9'd0, frame_byte};
                                if (nxt[16])
                                    scan_next = wefc_pkg::PH_STOP;
                                else
                                    cursor_next = nxt[15:0];
                            end
                        end
                    end
                    wefc_pkg::PH_CAND:
                    begin
                        start = {1'b0, cursor_reg} + 17'd2;
                        if ({1'b0, p} >= start && {1'b0, p} < start + {9'd0, ttl_reg[7:0]})
                        begin
                            c_en[0]  = 1'b1;
                            c_res[0] = wefc_pkg::byte_result(wefc_pkg::TAG_SSID,
                                frame_byte, 8'(({1'b0, p} - start)));
                        end
                        else if ({1'b0, p} == start + {9'd0, ttl_reg[7:0]})
                        begin
                            ssid_found_next = 1'b1;
                            scan_next       = wefc_pkg::PH_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                dok = ((fcw_next & wefc_pkg::FT_MASK) == wefc_pkg::FT_DATA) &&
                      (((fcw_next & wefc_pkg::DS_TO) != 16'd0) !=
                       ((fcw_next & wefc_pkg::DS_FROM) != 16'd0));
                lo  = ((fcw_next & wefc_pkg::ST_MASK) == wefc_pkg::ST_QOS) ? 16'd26 : 16'd24;
                if (dok && llc_reg && p >= lo)
                begin
                    if (p < lo + 16'd8)
                    begin
                        k   = 3'(p - lo);
                        bad = ((k == 3'd0 || k == 3'd1) && frame_byte != wefc_pkg::LLC_SAP) ||
                              (k == 3'd2 && frame_byte != wefc_pkg::LLC_CTRL) ||
                              (k == 3'd6 && frame_byte != wefc_pkg::DOT1X_TYPE[7:0]) ||
                              (k == 3'd7 && frame_byte != wefc_pkg::DOT1X_TYPE[15:8]);
                        if (bad)
                            llc_next = 1'b0;
                    end
                    else
                    begin
                        i = p - lo - 16'd8;
                        if (i == 16'd2 || i == 16'd3)
                            body_next = {body_reg[7:0], frame_byte};
                        else if (i == 16'd5 || i == 16'd6)
                            ki_next = {ki_reg[7:0], frame_byte};
                        else if (i >= 16'd9 && i <= 16'd16)
                            replay_next = {replay_reg[55:0], frame_byte};
                        else if (i == 16'd97 || i == 16'd98)
                            kdl_next = {kdl_reg[7:0], frame_byte};
                        if (i >= 16'd7)
                            m = wefc_pkg::msg_of(ki_next);
                        if (i >= 16'd17 && i <= 16'd48 && m != 2'd0)
                        begin
                            c_en[1]  = 1'b1;
                            c_res[1] = wefc_pkg::byte_result(wefc_pkg::TAG_NONCE,
                                frame_byte, 8'(i - 16'd17));
                        end
                        if ((i <= 16'd6 || m == 2'd2) &&
                            {1'b0, i} < 17'(EAPOL_CAPACITY) &&
                            ({1'b0, i} < {1'b0, wefc_pkg::AUTH_LEN} ||
                             {1'b0, i} < {1'b0, wefc_pkg::AUTH_LEN} + {1'b0, kdl_next}))
                        begin
                            c_en[2]  = 1'b1;
                            c_res[2] = wefc_pkg::byte_result(wefc_pkg::TAG_EAPOL,
                                (i >= 16'd81 && i <= 16'd96) ? 8'd0 : frame_byte, i[7:0]);
                        end
                        if (m == 2'd2 && i >= 16'd81 && i <= 16'd96)
                        begin
                            c_en[3]  = 1'b1;
                            c_res[3] = wefc_pkg::byte_result(wefc_pkg::TAG_MIC,
                                frame_byte, 8'(i - 16'd81));
                        end
                    end
                end
            end
        end

        if ({1'b0, pos_reg} < 17'(FRAME_LIMIT))
            pos_next = pos_reg + 16'd1;

        for (int j = 0; j < 4; j++)
        begin
            if (c_en[j])
            begin
                if (cnt == 2'd0)
                    res0 = c_res[j];
                else
                    res1 = c_res[j];
                cnt = cnt + 2'd1;
            end
        end

        if (frame_end)
        begin
            vr      = '0;
            vr.kind = 1'b1;
            dok = ((fcw_next & wefc_pkg::FT_MASK) == wefc_pkg::FT_DATA) &&
                  (((fcw_next & wefc_pkg::DS_TO) != 16'd0) !=
                   ((fcw_next & wefc_pkg::DS_FROM) != 16'd0));
            lo  = ((fcw_next & wefc_pkg::ST_MASK) == wefc_pkg::ST_QOS) ? 16'd26 : 16'd24;
            len = fm ? pos_next - prefix_next : pos_next;
            m   = wefc_pkg::msg_of(ki_next);
            el  = {1'b0, wefc_pkg::AUTH_LEN} + {1'b0, kdl_next};
            priority if (ferr_next == wefc_pkg::ERR_OVER)
                vr.verdict = wefc_pkg::VERD_DROP;
            else if (ferr_next == wefc_pkg::ERR_RADIO || (fm && pos_next < 16'd8))
                vr.verdict = wefc_pkg::VERD_RADIO;
            else if (fm && pos_next < prefix_next)
                vr.verdict = wefc_pkg::VERD_DROP;
            else if (ssid_found_next && ttl_next[7:0] != 8'd0)
            begin
                vr.verdict = wefc_pkg::VERD_NETWORK;
                vr.ap      = a3_next;
                vr.len     = {1'b0, ttl_next[7:0]};
            end
            else if (!dok || !llc_next)
                vr.verdict = wefc_pkg::VERD_DROP;
            else if ({1'b0, len} < {1'b0, lo} + 17'd8 + {1'b0, wefc_pkg::AUTH_LEN} ||
                     body_next == 16'd0)
                vr.verdict = wefc_pkg::VERD_DROP;
            else if (m == 2'd1 || m == 2'd3)
            begin
                vr.verdict = wefc_pkg::VERD_HSHAKE;
                vr.msg     = m;
                vr.rc      = (m == 2'd3) ? replay_next - 64'd1 : replay_next;
                vr.ap      = a2_next;
                vr.sta     = a1_next;
            end
            else if (m == 2'd2 && {1'b0, lo} + 17'd8 + el <= {1'b0, len} &&
                     el <= 17'(EAPOL_CAPACITY))
            begin
                vr.verdict = wefc_pkg::VERD_HSHAKE;
                vr.msg     = m;
                vr.kver    = ki_next[2:0];
                vr.rc      = replay_next;
                vr.ap      = a1_next;
                vr.sta     = a2_next;
                vr.len     = el[8:0];
            end
            else
                vr.verdict = wefc_pkg::VERD_DROP;

            if (cnt == 2'd0)
            begin
                res0 = vr;
                cnt  = 2'd1;
            end
            else
            begin
                res1 = vr;
                cnt  = 2'd2;
            end

            frame_mode_next = 1'b0;
            pos_next        = '0;
            prefix_next     = '0;
            fcw_next        = '0;
            a1_next         = '0;
            a2_next         = '0;
            a3_next         = '0;
            cursor_next     = '0;
            ttl_next        = '0;
            ssid_found_next = 1'b0;
            llc_next        = 1'b1;
            ki_next         = '0;
            body_next       = '0;
            kdl_next        = '0;
            replay_next     = '0;
            ferr_next       = wefc_pkg::ERR_NONE;
            scan_next       = wefc_pkg::PH_STOP;
        end

        if (cnt == 2'd1)
            res0.last = 1'b1;
        else if (cnt == 2'd2)
            res1.last = 1'b1;
        nres = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radiotap_mode_reg <= 1'b0;
            frame_mode_reg    <= 1'b0;
            pos_reg           <= '0;
            prefix_reg        <= '0;
            fcw_reg           <= '0;
            a1_reg            <= '0;
            a2_reg            <= '0;
            a3_reg            <= '0;
            cursor_reg        <= '0;
            ttl_reg           <= '0;
            ssid_found_reg    <= 1'b0;
            llc_reg           <= 1'b1;
            ki_reg            <= '0;
            body_reg          <= '0;
            kdl_reg           <= '0;
            replay_reg        <= '0;
            ferr_reg          <= wefc_pkg::ERR_NONE;
            scan_reg          <= wefc_pkg::PH_STOP;
        end
        else
        begin
            if (cfg_write)
                radiotap_mode_reg <= cfg_data;
            if (in_acc)
            begin
                frame_mode_reg <= frame_mode_next;
                pos_reg        <= pos_next;
                prefix_reg     <= prefix_next;
                fcw_reg        <= fcw_next;
                a1_reg         <= a1_next;
                a2_reg         <= a2_next;
                a3_reg         <= a3_next;
                cursor_reg     <= cursor_next;
                ttl_reg        <= ttl_next;
                ssid_found_reg <= ssid_found_next;
                llc_reg        <= llc_next;
                ki_reg         <= ki_next;
                body_reg       <= body_next;
                kdl_reg        <= kdl_next;
                replay_reg     <= replay_next;
                ferr_reg       <= ferr_next;
                scan_reg       <= scan_next;
            end
        end
    end

    // result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_acc)
                wr_ptr_reg <= wr_ptr_reg + nres;
            if (out_acc)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (in_acc ? {1'b0, nres} : 3'd0) - {2'd0, out_acc};
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (in_acc && nres != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (in_acc && nres == 2'd2)
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
    end

    assign result_kind     = queue_reg[rd_ptr_reg].kind;
    assign byte_tag        = queue_reg[rd_ptr_reg].tag;
    assign byte_value      = queue_reg[rd_ptr_reg].value;
    assign byte_index      = queue_reg[rd_ptr_reg].index;
    assign verdict         = queue_reg[rd_ptr_reg].verdict;
    assign message_number  = queue_reg[rd_ptr_reg].msg;
    assign key_version     = queue_reg[rd_ptr_reg].kver;
    assign replay_count    = queue_reg[rd_ptr_reg].rc;
    assign ap_mac          = queue_reg[rd_ptr_reg].ap;
    assign sta_mac         = queue_reg[rd_ptr_reg].sta;
    assign captured_length = queue_reg[rd_ptr_reg].len;
    assign run_last        = queue_reg[rd_ptr_reg].last;

    `WEFC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= 3'd4)
    `WEFC_ASSERT_IMP(a_verdict_last, out_valid && result_kind, run_last)
    `WEFC_ASSERT_NEXT(a_end_clears, in_acc && frame_end, pos_reg == 16'd0 && llc_reg)
    `WEFC_ASSERT_NEXT(a_end_queues, in_acc && frame_end && !out_acc, out_valid)

endmodule
